// ----- rtl/rpt_pkg.sv -----
// Shared types and constants for the radix page table walker.
package rpt_pkg;

	localparam int TABLE_SLOTS      = 16;
	localparam int ENTRY_SLOTS      = 4096;
	localparam int UPPER_LEVEL_BITS = 12;
	localparam int LEAF_LEVEL_BITS  = 8;

	localparam int SLOT_BITS   = (UPPER_LEVEL_BITS > LEAF_LEVEL_BITS) ?
		UPPER_LEVEL_BITS : LEAF_LEVEL_BITS;
	localparam int SLOT_SPAN   = 1 << SLOT_BITS;
	localparam int STORE_DEPTH = TABLE_SLOTS * SLOT_SPAN;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int TBL_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int MAX_SLOTS   = (TABLE_SLOTS > ENTRY_SLOTS) ? TABLE_SLOTS : ENTRY_SLOTS;
	localparam int CHILD_W     = $clog2(MAX_SLOTS + 1);
	localparam int STORE_W     = CHILD_W + 1;
	localparam int NFT_W       = $clog2(TABLE_SLOTS + 1);
	localparam int NFE_W       = $clog2(ENTRY_SLOTS + 1);

	localparam int FN_W     = 32;
	localparam int VW_W     = 6;
	localparam int KIND_W   = 2;
	localparam int HANDLE_W = 12;

	localparam logic [VW_W-1:0] VFN_RESET = VW_W'(20);
	localparam logic [VW_W-1:0] UPPER_W   = VW_W'(UPPER_LEVEL_BITS);
	localparam logic [VW_W-1:0] UPPER2_W  = VW_W'(2 * UPPER_LEVEL_BITS);
	localparam logic [VW_W-1:0] MAX_W     = VW_W'(2 * UPPER_LEVEL_BITS + LEAF_LEVEL_BITS);

	typedef struct packed {
		logic [FN_W-1:0]   frame_number;
		logic [KIND_W-1:0] access_kind;
	} req_item_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] entry_handle;
		logic                compulsory_miss;
		logic [KIND_W-1:0]   miss_kind;
		logic                out_of_space;
	} rsp_item_t;

	// Per-walk level indexes; last is the number of the leaf level.
	typedef struct packed {
		logic [1:0]                 last;
		logic [2:0][SLOT_BITS-1:0]  idx;
	} idx_set_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [STORE_W-1:0] data;
	} store_wr_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_HOLD
	} state_t;

endpackage

// ----- rtl/rpt_store.sv -----
// Table store: one write port, one registered read port.
module rpt_store (
	input  logic                          clk,
	input  rpt_pkg::store_wr_t            wr,
	input  logic [rpt_pkg::ADDR_W-1:0]    rd_addr,
	output logic [rpt_pkg::STORE_W-1:0]   rd_data
);

	logic [rpt_pkg::STORE_W-1:0] mem [rpt_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/rpt_index.sv -----
// Splits a frame number into per-level table indexes for the configured width.
module rpt_index (
	input  logic [rpt_pkg::FN_W-1:0] frame_number,
	input  logic [rpt_pkg::VW_W-1:0] vfn_width,
	output rpt_pkg::idx_set_t        idx_set
);

	logic [rpt_pkg::VW_W-1:0] w;
	logic [rpt_pkg::FN_W-1:0] fn;
	logic [rpt_pkg::VW_W-1:0] sh0, sh1, sz0, sz1, sz2;

	function automatic logic [rpt_pkg::SLOT_BITS-1:0] lvl_idx(
		input logic [rpt_pkg::FN_W-1:0] f,
		input logic [rpt_pkg::VW_W-1:0] sh,
		input logic [rpt_pkg::VW_W-1:0] sz
	);
		logic [rpt_pkg::FN_W-1:0] v;
		logic [rpt_pkg::FN_W-1:0] m;
		v = f >> sh;
		m = (sz >= rpt_pkg::VW_W'(rpt_pkg::FN_W)) ? '1 :
			((rpt_pkg::FN_W'(1) << sz) - rpt_pkg::FN_W'(1));
		v = v & m;
		return v[rpt_pkg::SLOT_BITS-1:0];
	endfunction

	always_comb begin
		w = (vfn_width > rpt_pkg::MAX_W) ? rpt_pkg::MAX_W : vfn_width;
		fn = (w >= rpt_pkg::VW_W'(rpt_pkg::FN_W)) ? frame_number :
			(frame_number & ((rpt_pkg::FN_W'(1) << w) - rpt_pkg::FN_W'(1)));
		sh0 = '0;
		sh1 = '0;
		sz0 = w;
		sz1 = '0;
		sz2 = '0;
		idx_set = '0;
		if (w <= rpt_pkg::UPPER_W) begin
			idx_set.last = 2'd0;
		end else if (w <= rpt_pkg::UPPER2_W) begin
			idx_set.last = 2'd1;
			sz0 = rpt_pkg::UPPER_W;
			sh0 = w - rpt_pkg::UPPER_W;
			sz1 = w - rpt_pkg::UPPER_W;
		end else begin
			idx_set.last = 2'd2;
			sz0 = rpt_pkg::UPPER_W;
			sh0 = w - rpt_pkg::UPPER_W;
			sz1 = rpt_pkg::UPPER_W;
			sh1 = w - rpt_pkg::UPPER2_W;
			sz2 = w - rpt_pkg::UPPER2_W;
		end
		idx_set.idx[0] = lvl_idx(fn, sh0, sz0);
		idx_set.idx[1] = lvl_idx(fn, sh1, sz1);
		idx_set.idx[2] = lvl_idx(fn, '0, sz2);
	end

endmodule

// ----- rtl/radix_page_table_walk_alloc.sv -----
// Top level: radix page table walker with on-demand table and entry allocation.
//
// Requests (req_valid/req_stall/req_data) carry a frame number and access kind;
// responses (rsp_valid/rsp_stall/rsp_data) carry the entry handle and flags.
// cfg_valid/cfg_ready/cfg_data writes vfn_width; cfg_ready is always high.
// A width write empties the table and resets both allocation counters.
//
// A walk of n levels (1 to 3, set by vfn_width) reads one store slot per
// level: ST_READ issues the read, and ST_CHECK checks it and writes any new
// table or entry. The response is registered at the end of the final check,
// and the next request is taken only once the walk is back in ST_IDLE.
// The walk is a chain of dependent registered store reads.
//
// After reset and after each width write the store is swept clear, one slot
// a cycle, over all STORE_DEPTH (65536) slots; req_stall is high meanwhile.
// The response sits in an output register. If the receiver stalls it, the
// next walk still runs and its result waits in a hold register until the
// output is free; no further request is taken until it moves out.
module radix_page_table_walk_alloc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  rpt_pkg::req_item_t          req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output rpt_pkg::rsp_item_t          rsp_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rpt_pkg::VW_W-1:0]    cfg_data
);

	rpt_pkg::state_t state_q, state_d;

	logic [rpt_pkg::VW_W-1:0]    vfn_q;
	logic [rpt_pkg::NFT_W-1:0]   nft_q;
	logic [rpt_pkg::NFE_W-1:0]   nfe_q;
	logic [rpt_pkg::ADDR_W-1:0]  clr_q;
	logic [rpt_pkg::TBL_W-1:0]   slot_q;
	logic [1:0]                  lvl_q;
	logic [rpt_pkg::KIND_W-1:0]  kind_q;
	rpt_pkg::idx_set_t           idx_q;
	rpt_pkg::idx_set_t           idx_set;
	rpt_pkg::rsp_item_t          hold_q;
	rpt_pkg::rsp_item_t          rsp_q;
	logic                        rsp_valid_q;

	rpt_pkg::store_wr_t          wr;
	logic [rpt_pkg::ADDR_W-1:0]  addr_cur;
	logic [rpt_pkg::STORE_W-1:0] rd_data;
	logic                        ent_valid;
	logic [rpt_pkg::CHILD_W-1:0] child;
	logic [rpt_pkg::CHILD_W-1:0] child_d;
	logic [31:0]                 wide;
	rpt_pkg::rsp_item_t          res;
	logic                        rsp_free;
	logic                        load_walk;
	logic                        step;
	logic                        fin;
	logic                        emit_hold;
	logic                        alloc_t;
	logic                        alloc_e;

	rpt_index u_index (
		.frame_number (req_data.frame_number),
		.vfn_width    (vfn_q),
		.idx_set      (idx_set)
	);

	rpt_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (addr_cur),
		.rd_data (rd_data)
	);

	assign addr_cur  = rpt_pkg::ADDR_W'({slot_q, idx_q.idx[lvl_q]});
	assign ent_valid = rd_data[rpt_pkg::CHILD_W];
	assign child     = rd_data[rpt_pkg::CHILD_W-1:0];
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	// hold requests off outside idle and while a width write restarts the sweep
	assign req_stall = (state_q != rpt_pkg::ST_IDLE) || cfg_valid;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		wr        = '0;
		res       = '0;
		child_d   = child;
		wide      = '0;
		load_walk = 1'b0;
		step      = 1'b0;
		fin       = 1'b0;
		emit_hold = 1'b0;
		alloc_t   = 1'b0;
		alloc_e   = 1'b0;
		case (state_q)
			rpt_pkg::ST_CLEAR: begin
				wr.en   = 1'b1;
				wr.addr = clr_q;
				if (clr_q == rpt_pkg::ADDR_W'(rpt_pkg::STORE_DEPTH - 1)) begin
					state_d = rpt_pkg::ST_IDLE;
				end
			end
			rpt_pkg::ST_IDLE: begin
				if (req_valid) begin
					load_walk = 1'b1;
					state_d   = rpt_pkg::ST_READ;
				end
			end
			rpt_pkg::ST_READ: begin
				state_d = rpt_pkg::ST_CHECK;
			end
			rpt_pkg::ST_CHECK: begin
				if (lvl_q == idx_q.last) begin
					fin = 1'b1;
					if (ent_valid) begin
						wide = 32'(child);
						res.entry_handle = wide[rpt_pkg::HANDLE_W-1:0];
					end else if (nfe_q >= rpt_pkg::NFE_W'(rpt_pkg::ENTRY_SLOTS)) begin
						res.out_of_space = 1'b1;
					end else begin
						// create the leaf entry and flag the first touch
						wr.en   = 1'b1;
						wr.addr = addr_cur;
						wr.data = {1'b1, rpt_pkg::CHILD_W'(nfe_q)};
						alloc_e = 1'b1;
						wide    = 32'(nfe_q);
						res.entry_handle    = wide[rpt_pkg::HANDLE_W-1:0];
						res.compulsory_miss = 1'b1;
						res.miss_kind       = kind_q;
					end
				end else begin
					if (!ent_valid) begin
						if (nft_q >= rpt_pkg::NFT_W'(rpt_pkg::TABLE_SLOTS)) begin
							fin = 1'b1;
							res.out_of_space = 1'b1;
						end else begin
							wr.en   = 1'b1;
							wr.addr = addr_cur;
							wr.data = {1'b1, rpt_pkg::CHILD_W'(nft_q)};
							alloc_t = 1'b1;
							child_d = rpt_pkg::CHILD_W'(nft_q);
						end
					end
					// a child number past the table pool ends the walk
					if (!fin && (32'(child_d) >= 32'(rpt_pkg::TABLE_SLOTS))) begin
						fin = 1'b1;
						res.out_of_space = 1'b1;
					end
					if (!fin) begin
						step    = 1'b1;
						state_d = rpt_pkg::ST_READ;
					end
				end
				if (fin) begin
					state_d = rsp_free ? rpt_pkg::ST_IDLE : rpt_pkg::ST_HOLD;
				end
			end
			rpt_pkg::ST_HOLD: begin
				if (rsp_free) begin
					emit_hold = 1'b1;
					state_d   = rpt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rpt_pkg::ST_CLEAR;
			end
		endcase
		// a width write restarts the clearing sweep
		if (cfg_valid) begin
			state_d = rpt_pkg::ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vfn_q       <= rpt_pkg::VFN_RESET;
			nft_q       <= rpt_pkg::NFT_W'(1);
			nfe_q       <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				vfn_q <= cfg_data;
				nft_q <= rpt_pkg::NFT_W'(1);
				nfe_q <= '0;
				clr_q <= '0;
			end else begin
				if (state_q == rpt_pkg::ST_CLEAR) begin
					clr_q <= clr_q + rpt_pkg::ADDR_W'(1);
				end
				if (alloc_t) begin
					nft_q <= nft_q + rpt_pkg::NFT_W'(1);
				end
				if (alloc_e) begin
					nfe_q <= nfe_q + rpt_pkg::NFE_W'(1);
				end
			end
			if (rsp_free) begin
				rsp_valid_q <= (fin || emit_hold);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_walk) begin
			idx_q  <= idx_set;
			kind_q <= req_data.access_kind;
			slot_q <= '0;
			lvl_q  <= '0;
		end
		if (step) begin
			slot_q <= rpt_pkg::TBL_W'(child_d);
			lvl_q  <= lvl_q + 2'd1;
		end
		if (fin && !rsp_free) begin
			hold_q <= res;
		end
		if (fin && rsp_free) begin
			rsp_q <= res;
		end else if (emit_hold) begin
			rsp_q <= hold_q;
		end
	end

	a_oos_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.out_of_space |->
			rsp_data.entry_handle == '0 && !rsp_data.compulsory_miss &&
			rsp_data.miss_kind == '0)
		else $error("out_of_space response carries a handle or miss flag");

	a_miss_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.compulsory_miss |-> rsp_data.miss_kind == '0)
		else $error("miss kind set without a compulsory miss");

	a_pool_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		nft_q <= rpt_pkg::NFT_W'(rpt_pkg::TABLE_SLOTS) &&
		nfe_q <= rpt_pkg::NFE_W'(rpt_pkg::ENTRY_SLOTS))
		else $error("allocation counter past its pool");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=>
			state_q == rpt_pkg::ST_CLEAR && clr_q == '0 && nft_q == rpt_pkg::NFT_W'(1))
		else $error("width write did not restart the clear sweep");

	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !cfg_valid |=>
			state_q == rpt_pkg::ST_READ && lvl_q == 2'd0 && slot_q == '0)
		else $error("accepted request did not start a walk at the root");

endmodule
